// ===== rtl/bfms_pkg.sv =====
`default_nettype none

package bfms_pkg;

  // Ring size and the widths that follow from it.
  localparam int unsigned DEPTH = 64;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  // Payload field types.
  typedef logic [2:0] req_t;
  typedef logic [7:0] data_t;
  typedef logic [1:0] mode_t;
  typedef logic [2:0] ret_t;
  typedef logic [6:0] level_t;
  typedef logic [AW-1:0] ptr_t;
  typedef logic [CW-1:0] cnt_t;

  // Request codes.
  localparam req_t REQ_PUSH   = 3'd0;
  localparam req_t REQ_POP    = 3'd1;
  localparam req_t REQ_MODE   = 3'd2;
  localparam req_t REQ_CLEAR  = 3'd3;
  localparam req_t REQ_PROC   = 3'd4;
  localparam req_t REQ_INIT   = 3'd5;
  localparam req_t REQ_DEINIT = 3'd6;

  // Return codes.
  localparam ret_t RET_OK      = 3'd0;
  localparam ret_t RET_FULL    = 3'd1;
  localparam ret_t RET_EMPTY   = 3'd2;
  localparam ret_t RET_NOINIT  = 3'd3;
  localparam ret_t RET_BADMODE = 3'd4;

  // Operating modes.
  localparam mode_t MODE_IDLE = 2'd0;
  localparam mode_t MODE_RUN  = 2'd1;
  localparam mode_t MODE_DIAG = 2'd2;

  // Advance a ring pointer with wrap at the ring size.
  function automatic ptr_t ptr_inc(input ptr_t p);
    ptr_t r;
    if (p == ptr_t'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bfms_ifs.sv =====
`default_nettype none

// Request channel.
interface bfms_in_if import bfms_pkg::*; ;
  logic  valid;
  logic  ready;
  req_t  req_type;
  data_t push_byte;
  mode_t new_mode;

  modport source (output valid, output req_type, output push_byte, output new_mode,
                  input ready);
  modport sink (input valid, input req_type, input push_byte, input new_mode,
                output ready);
endinterface

// Result channel.
interface bfms_out_if import bfms_pkg::*; ;
  logic   valid;
  logic   ready;
  ret_t   ret_code;
  data_t  pop_byte;
  mode_t  cur_mode;
  level_t fill_level;
  logic   init_flag;
  logic   err_flag;
  logic   ovf_flag;

  modport source (output valid, output ret_code, output pop_byte, output cur_mode,
                  output fill_level, output init_flag, output err_flag,
                  output ovf_flag, input ready);
  modport sink (input valid, input ret_code, input pop_byte, input cur_mode,
                input fill_level, input init_flag, input err_flag,
                input ovf_flag, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfms_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port.
// A read of the address being written in the same cycle returns the new data.
module bfms_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AddrW-1:0] wa,
  input  wire logic [Width-1:0] wd,
  input  wire logic [AddrW-1:0] ra,
  output logic      [Width-1:0] rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // Read port with write-to-read bypass on an address match.
  always_ff @(posedge clk) begin
    if (we && (wa == ra)) begin
      rdata_r <= wd;
    end else begin
      rdata_r <= mem[ra];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== rtl/byte_fifo_with_mode_and_scramble.sv =====
// Channel   Direction  Role    Content
// in_ch     input      sink    req_type, push_byte, new_mode
// out_ch    output     source  ret_code, pop_byte, cur_mode, fill_level, flags
//
// Push, set mode, clear, init, deinit and a process request that does no walk
// give their result in the cycle after the transfer; a pop that returns a
// byte passes the RAM's read register, then the result register. A process
// request in run mode with bytes held walks the ring once, one entry a cycle
// through the RAM's read and write ports. One request is in flight at a time;
// in_ready is low while a pop or walk is busy or while a result waits.
// Synchronous reset sets the init flag and clears the other control state;
// the byte RAM is not cleared and holds no valid data until written.
`default_nettype none

module byte_fifo_with_mode_and_scramble import bfms_pkg::*; (
  input wire logic    clk,
  input wire logic    rst_n,
  bfms_in_if.sink     in_ch,
  bfms_out_if.source  out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_POP  = 2'd1;
  localparam logic [1:0] ST_WALK = 2'd2;

  logic [1:0] state_r, state_nxt;
  ptr_t       wr_r, wr_nxt;
  ptr_t       rd_r, rd_nxt;
  cnt_t       cnt_r, cnt_nxt;
  mode_t      mode_r, mode_nxt;
  logic       init_r, init_nxt;
  logic       err_r, err_nxt;
  logic       ovf_r, ovf_nxt;
  data_t      tick_r, tick_nxt;
  ptr_t       pass_r, pass_nxt;
  logic       out_valid_r, out_valid_nxt;
  ret_t       ret_r, ret_nxt;
  data_t      popb_r, popb_nxt;

  logic  in_ready;
  logic  in_fire;
  logic  ram_we;
  ptr_t  ram_wa;
  data_t ram_wd;
  ptr_t  ram_ra;
  data_t ram_rdata;

  bfms_ram #(
    .Depth (DEPTH),
    .Width (8)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .wa    (ram_wa),
    .wd    (ram_wd),
    .ra    (ram_ra),
    .rdata (ram_rdata)
  );

  // Take a request only when idle and the result slot is free or emptying.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_fire  = in_ch.valid && in_ready;

  // Request decode, pop completion and the process walk.
  always_comb begin
    state_nxt     = state_r;
    wr_nxt        = wr_r;
    rd_nxt        = rd_r;
    cnt_nxt       = cnt_r;
    mode_nxt      = mode_r;
    init_nxt      = init_r;
    err_nxt       = err_r;
    ovf_nxt       = ovf_r;
    tick_nxt      = tick_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    ret_nxt       = ret_r;
    popb_nxt      = popb_r;
    ram_we        = 1'b0;
    ram_wa        = wr_r;
    ram_wd        = in_ch.push_byte;
    ram_ra        = rd_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          out_valid_nxt = 1'b1;
          ret_nxt       = RET_OK;
          popb_nxt      = '0;
          unique case (in_ch.req_type)
            REQ_PUSH: begin
              if (!init_r) begin
                err_nxt = 1'b1;
                ret_nxt = RET_NOINIT;
              end else if (cnt_r == cnt_t'(DEPTH)) begin
                ovf_nxt = 1'b1;
                ret_nxt = RET_FULL;
              end else begin
                ram_we  = 1'b1;
                wr_nxt  = ptr_inc(wr_r);
                cnt_nxt = cnt_r + 1'b1;
                ovf_nxt = 1'b0;
              end
            end
            REQ_POP: begin
              if (!init_r) begin
                err_nxt = 1'b1;
                ret_nxt = RET_NOINIT;
              end else if (cnt_r == '0) begin
                ret_nxt = RET_EMPTY;
              end else begin
                // The read issues now; the byte is taken from the RAM's read register in ST_POP.
                rd_nxt        = ptr_inc(rd_r);
                cnt_nxt       = cnt_r - 1'b1;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_POP;
              end
            end
            REQ_MODE: begin
              if (!init_r) begin
                err_nxt = 1'b1;
                ret_nxt = RET_NOINIT;
              end else if ((in_ch.new_mode != MODE_IDLE) && (in_ch.new_mode != MODE_RUN) &&
                           (in_ch.new_mode != MODE_DIAG)) begin
                err_nxt = 1'b1;
                ret_nxt = RET_BADMODE;
              end else begin
                mode_nxt = in_ch.new_mode;
                err_nxt  = 1'b0;
              end
            end
            REQ_CLEAR: begin
              wr_nxt  = '0;
              rd_nxt  = '0;
              cnt_nxt = '0;
              err_nxt = 1'b0;
              ovf_nxt = 1'b0;
            end
            REQ_PROC: begin
              tick_nxt = tick_r + 1'b1;
              if ((mode_r == MODE_RUN) && (cnt_r != '0)) begin
                // The first read of the walk issues now.
                ovf_nxt       = 1'b0;
                pass_nxt      = '0;
                out_valid_nxt = 1'b0;
                state_nxt     = ST_WALK;
              end
            end
            REQ_INIT, REQ_DEINIT: begin
              wr_nxt   = '0;
              rd_nxt   = '0;
              cnt_nxt  = '0;
              mode_nxt = MODE_IDLE;
              err_nxt  = 1'b0;
              ovf_nxt  = 1'b0;
              init_nxt = (in_ch.req_type == REQ_INIT);
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        out_valid_nxt = 1'b1;
        ret_nxt       = RET_OK;
        popb_nxt      = ram_rdata;
        state_nxt     = ST_IDLE;
      end
      ST_WALK: begin
        // Write back the front byte scrambled with the tick and fetch the next.
        ram_we = 1'b1;
        ram_wa = wr_r;
        ram_wd = ram_rdata ^ tick_r;
        ram_ra = ptr_inc(rd_r);
        wr_nxt = ptr_inc(wr_r);
        rd_nxt = ptr_inc(rd_r);
        if (pass_r == ptr_t'(DEPTH - 1)) begin
          out_valid_nxt = 1'b1;
          ret_nxt       = RET_OK;
          popb_nxt      = '0;
          state_nxt     = ST_IDLE;
        end else begin
          pass_nxt = pass_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wr_r        <= '0;
      rd_r        <= '0;
      cnt_r       <= '0;
      mode_r      <= MODE_IDLE;
      init_r      <= 1'b1;
      err_r       <= 1'b0;
      ovf_r       <= 1'b0;
      tick_r      <= '0;
      pass_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_r        <= wr_nxt;
      rd_r        <= rd_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      init_r      <= init_nxt;
      err_r       <= err_nxt;
      ovf_r       <= ovf_nxt;
      tick_r      <= tick_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    ret_r  <= ret_nxt;
    popb_r <= popb_nxt;
  end

  // The status registers do not move while a result is held, so the
  // snapshot fields come straight from them.
  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.ret_code   = ret_r;
  assign out_ch.pop_byte   = popb_r;
  assign out_ch.cur_mode   = mode_r;
  assign out_ch.fill_level = level_t'(cnt_r);
  assign out_ch.init_flag  = init_r;
  assign out_ch.err_flag   = err_r;
  assign out_ch.ovf_flag   = ovf_r;

endmodule

`default_nettype wire

// ===== rtl/bfms_chk.sv =====
`default_nettype none

module bfms_chk import bfms_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  input wire logic   in_ready,
  input wire logic   out_valid,
  input wire logic   out_ready,
  input wire ret_t   ret_code,
  input wire data_t  pop_byte,
  input wire mode_t  cur_mode,
  input wire level_t fill_level,
  input wire logic   init_flag,
  input wire logic   ovf_flag
);

  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ret_code) && $stable(pop_byte) &&
    $stable(fill_level))
    else $error("result changed while stalled");

  // No new request is taken while a result is stuck.
  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while a result is stalled");

  // Only a successful pop carries a byte.
  a_pop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (ret_code != RET_OK) |-> pop_byte == '0)
    else $error("failed request carries a byte");

  // The ring never reports more than it holds.
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> fill_level <= level_t'(DEPTH))
    else $error("fill level beyond ring size");

  // Without init the ring stays empty, idle and without overflow.
  a_uninit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !init_flag |-> (fill_level == '0) && (cur_mode == MODE_IDLE) && !ovf_flag)
    else $error("uninitialized block holds data or mode");

endmodule

bind byte_fifo_with_mode_and_scramble bfms_chk u_bfms_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .ret_code   (out_ch.ret_code),
  .pop_byte   (out_ch.pop_byte),
  .cur_mode   (out_ch.cur_mode),
  .fill_level (out_ch.fill_level),
  .init_flag  (out_ch.init_flag),
  .ovf_flag   (out_ch.ovf_flag)
);

`default_nettype wire

// ===== dv/tb_byte_fifo_with_mode_and_scramble.sv =====
`default_nettype none

module tb_byte_fifo_with_mode_and_scramble;
  import bfms_pkg::*;

  // Codes that the package leaves unnamed.
  localparam req_t  REQ_NOP  = 3'd7;
  localparam mode_t MODE_BAD = 2'd3;

  localparam int N_DIRECTED  = 27;
  localparam int RAND_ITEMS  = 1120;
  localparam int CALM_ITEMS  = 150;
  localparam int QUIET_LIMIT = 5000;
  localparam int HOLD_AT     = 1500;
  localparam int HOLD_SPAN   = 500;

  // One result as the block reports it.
  typedef struct packed {
    ret_t   ret_code;
    data_t  pop_byte;
    mode_t  cur_mode;
    level_t fill_level;
    logic   init_flag;
    logic   err_flag;
    logic   ovf_flag;
  } status_t;

  // One row of the directed script; reps repeats the row with the byte counting up.
  typedef struct packed {
    req_t       req;
    data_t      pbyte;
    mode_t      mode;
    logic [7:0] reps;
    logic       has_want;
    status_t    want;
  } step_row_t;

  localparam status_t NO_WANT = '0;

  localparam step_row_t DIRECTED [N_DIRECTED] = '{
    '{REQ_POP,    8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_EMPTY,   8'h00, MODE_IDLE, 7'd0,  1'b1, 1'b0, 1'b0}},
    '{REQ_PUSH,   8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_IDLE, 7'd1,  1'b1, 1'b0, 1'b0}},
    '{REQ_PUSH,   8'hFF, MODE_IDLE, 8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_IDLE, 7'd2,  1'b1, 1'b0, 1'b0}},
    '{REQ_MODE,   8'h00, MODE_BAD,  8'd1,  1'b1,
      '{RET_BADMODE, 8'h00, MODE_IDLE, 7'd2,  1'b1, 1'b1, 1'b0}},
    '{REQ_MODE,   8'h00, MODE_RUN,  8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_RUN,  7'd2,  1'b1, 1'b0, 1'b0}},
    '{REQ_PROC,   8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_POP,    8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_PUSH,   8'h80, MODE_IDLE, 8'd63, 1'b0, NO_WANT},
    '{REQ_PUSH,   8'hA5, MODE_IDLE, 8'd1,  1'b1,
      '{RET_FULL,    8'h00, MODE_RUN,  7'd64, 1'b1, 1'b0, 1'b1}},
    '{REQ_PROC,   8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_PUSH,   8'h5A, MODE_IDLE, 8'd1,  1'b1,
      '{RET_FULL,    8'h00, MODE_RUN,  7'd64, 1'b1, 1'b0, 1'b1}},
    '{REQ_POP,    8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_PUSH,   8'h33, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_MODE,   8'h00, MODE_DIAG, 8'd1,  1'b0, NO_WANT},
    '{REQ_PROC,   8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_NOP,    8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_CLEAR,  8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_DIAG, 7'd0,  1'b1, 1'b0, 1'b0}},
    '{REQ_MODE,   8'h00, MODE_RUN,  8'd1,  1'b0, NO_WANT},
    '{REQ_PROC,   8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_PUSH,   8'h01, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_DEINIT, 8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_IDLE, 7'd0,  1'b0, 1'b0, 1'b0}},
    '{REQ_PUSH,   8'h12, MODE_IDLE, 8'd1,  1'b1,
      '{RET_NOINIT,  8'h00, MODE_IDLE, 7'd0,  1'b0, 1'b1, 1'b0}},
    '{REQ_POP,    8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_NOINIT,  8'h00, MODE_IDLE, 7'd0,  1'b0, 1'b1, 1'b0}},
    '{REQ_MODE,   8'h00, MODE_RUN,  8'd1,  1'b1,
      '{RET_NOINIT,  8'h00, MODE_IDLE, 7'd0,  1'b0, 1'b1, 1'b0}},
    '{REQ_CLEAR,  8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_IDLE, 7'd0,  1'b0, 1'b0, 1'b0}},
    '{REQ_PROC,   8'h00, MODE_IDLE, 8'd1,  1'b0, NO_WANT},
    '{REQ_INIT,   8'h00, MODE_IDLE, 8'd1,  1'b1,
      '{RET_OK,      8'h00, MODE_IDLE, 7'd0,  1'b1, 1'b0, 1'b0}}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bfms_in_if  in_ch ();
  bfms_out_if out_ch ();

  byte_fifo_with_mode_and_scramble DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow of the block state: the held bytes in order, oldest first.
  data_t      ring_bytes [$];
  mode_t      mode_st = MODE_IDLE;
  logic       init_st = 1'b1;
  logic       err_st  = 1'b0;
  logic       ovf_st  = 1'b0;
  logic [7:0] tick_st = 8'd0;

  status_t pending_status [$];
  int      mismatch_count = 0;
  bit      calm = 1'b0;
  int      quiet_cycles = 0;

  // Apply one request to the shadow state and return the status it reports.
  function automatic status_t predict_status(input req_t r, input data_t b, input mode_t m);
    status_t s;
    data_t   v;
    s = '0;
    case (r)
      REQ_PUSH: begin
        if (!init_st) begin
          err_st = 1'b1;
          s.ret_code = RET_NOINIT;
        end else if (ring_bytes.size() >= DEPTH) begin
          ovf_st = 1'b1;
          s.ret_code = RET_FULL;
        end else begin
          ring_bytes.push_back(b);
          ovf_st = 1'b0;
        end
      end
      REQ_POP: begin
        if (!init_st) begin
          err_st = 1'b1;
          s.ret_code = RET_NOINIT;
        end else if (ring_bytes.size() == 0) begin
          s.ret_code = RET_EMPTY;
        end else begin
          s.pop_byte = ring_bytes.pop_front();
        end
      end
      REQ_MODE: begin
        if (!init_st) begin
          err_st = 1'b1;
          s.ret_code = RET_NOINIT;
        end else if (m == MODE_BAD) begin
          err_st = 1'b1;
          s.ret_code = RET_BADMODE;
        end else begin
          mode_st = m;
          err_st = 1'b0;
        end
      end
      REQ_CLEAR: begin
        ring_bytes.delete();
        err_st = 1'b0;
        ovf_st = 1'b0;
      end
      REQ_PROC: begin
        // The tick always advances; the scramble walk runs only in run mode with data.
        tick_st = tick_st + 8'd1;
        if (mode_st == MODE_RUN && ring_bytes.size() != 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            v = ring_bytes.pop_front();
            ring_bytes.push_back(v ^ tick_st);
          end
          ovf_st = 1'b0;
        end
      end
      REQ_INIT, REQ_DEINIT: begin
        ring_bytes.delete();
        mode_st = MODE_IDLE;
        err_st  = 1'b0;
        ovf_st  = 1'b0;
        init_st = (r == REQ_INIT);
      end
      default: begin
      end
    endcase
    s.cur_mode   = mode_st;
    s.fill_level = level_t'(ring_bytes.size());
    s.init_flag  = init_st;
    s.err_flag   = err_st;
    s.ovf_flag   = ovf_st;
    return s;
  endfunction

  // Offer one request, wait for its transfer, then record what it should report.
  task automatic send_req(input req_t r, input data_t b, input mode_t m,
                          input logic has_want, input status_t want);
    status_t pred;
    in_ch.valid     <= 1'b1;
    in_ch.req_type  <= r;
    in_ch.push_byte <= b;
    in_ch.new_mode  <= m;
    do @(posedge clk); while (!in_ch.ready);
    pred = predict_status(r, b, m);
    pending_status.push_back(has_want ? want : pred);
  endtask

  // Random gap on the request side, skipped once the run has calmed down.
  task automatic sender_gap();
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  // Request side: reset, directed script, then random traffic.
  initial begin : request_driver
    step_row_t row;
    req_t      r;
    mode_t     m;
    int        pick;
    bit        fill_phase;
    in_ch.valid     <= 1'b0;
    in_ch.req_type  <= REQ_PUSH;
    in_ch.push_byte <= '0;
    in_ch.new_mode  <= MODE_IDLE;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      for (int k = 0; k < int'(row.reps); k++) begin
        send_req(row.req, row.pbyte + data_t'(k), row.mode, row.has_want, row.want);
        sender_gap();
      end
    end

    // Alternate fill-heavy and drain-heavy stretches so the ring reaches both ends.
    fill_phase = 1'b0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) fill_phase = ~fill_phase;
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      pick = $urandom_range(0, 99);
      if (fill_phase && !init_st) r = REQ_INIT;
      else if (pick < (fill_phase ? 75 : 20)) r = REQ_PUSH;
      else if (pick < 80) r = REQ_POP;
      else if (pick < 89) r = REQ_MODE;
      else if (pick < 96) r = REQ_PROC;
      else if (fill_phase) r = REQ_PUSH;
      else if (pick == 96) r = REQ_CLEAR;
      else if (pick == 97) r = REQ_INIT;
      else if (pick == 98) r = REQ_DEINIT;
      else r = REQ_NOP;
      m = ($urandom_range(0, 1) != 0) ? MODE_RUN : mode_t'($urandom_range(0, 3));
      send_req(r, data_t'($urandom), m, 1'b0, NO_WANT);
      sender_gap();
    end
    in_ch.valid <= 1'b0;

    // Drain, then allow a full walk's worth of cycles for any stray result.
    while (pending_status.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_byte_fifo_with_mode_and_scramble: clean");
    end else begin
      $display("tb_byte_fifo_with_mode_and_scramble: errors");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off to back up the request side.
  initial begin : ready_driver
    int span;
    int rx_cycles;
    bit held_off;
    out_ch.ready <= 1'b0;
    rx_cycles = 0;
    held_off  = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (!held_off && rx_cycles >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        span = HOLD_SPAN;
        held_off = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        span = $urandom_range(1, 18);
      end else begin
        out_ch.ready <= 1'b1;
        span = $urandom_range(1, 24);
      end
      repeat (span) @(posedge clk);
      rx_cycles += span;
    end
  end

  // Compare every result transfer against the oldest expectation.
  always @(posedge clk) begin : result_check
    status_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_status.size() == 0) begin
        $error("result transfer with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("ret_code",   8'(want.ret_code),   8'(out_ch.ret_code));
        check_field("pop_byte",   want.pop_byte,       out_ch.pop_byte);
        check_field("cur_mode",   8'(want.cur_mode),   8'(out_ch.cur_mode));
        check_field("fill_level", 8'(want.fill_level), 8'(out_ch.fill_level));
        check_field("init_flag",  8'(want.init_flag),  8'(out_ch.init_flag));
        check_field("err_flag",   8'(want.err_flag),   8'(out_ch.err_flag));
        check_field("ovf_flag",   8'(want.ovf_flag),   8'(out_ch.ovf_flag));
      end
    end
  end

  // Watchdog: give up when neither channel has moved for too long.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_byte_fifo_with_mode_and_scramble: errors");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/bfms_pkg.sv
rtl/bfms_ifs.sv
rtl/bfms_ram.sv
rtl/byte_fifo_with_mode_and_scramble.sv
rtl/bfms_chk.sv
dv/tb_byte_fifo_with_mode_and_scramble.sv
